FILE: src/rsa_pkg.sv
package rsa_pkg;

  localparam logic [1:0] ACT_FIND      = 2'd0;
  localparam logic [1:0] ACT_MARK_USED = 2'd1;
  localparam logic [1:0] ACT_MARK_FREE = 2'd2;

  localparam int unsigned COORD_MAX = 127;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] x_pos;
    logic [6:0] y_pos;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
    logic [6:0] bound_x;
    logic [6:0] bound_y;
    logic [7:0] bound_w;
    logic [7:0] bound_h;
    logic       top_to_bottom;
    logic       left_to_right;
    logic       row_first;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [6:0] result_x;
    logic [6:0] result_y;
  } out_t;

endpackage

FILE: src/rect_space_allocator.sv
// after reset a clearing pass over every grid row runs with busy high
// mark: a setup state plus a read and a write back per grid row touched
// find: setup and done states plus a read and a check per bitmap row read, over every
//   candidate tried until one fits; worst case grows with window size times rect height
// one item at a time through the single-port row memory; busy high until done
// find result strobe in the cycle after done, as busy drops; the receiver cannot stall
module rect_space_allocator #(
  parameter int GRID_ROWS = 128,
  parameter int GRID_COLS = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rsa_pkg::in_t  in_item,
  output logic          out_valid,
  output rsa_pkg::out_t out_item
);
  import rsa_pkg::*;

  localparam int MAXG = (GRID_ROWS > GRID_COLS) ? GRID_ROWS : GRID_COLS;
  localparam int SW   = $clog2(MAXG + 256) + 1;
  localparam int AW   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MSET, S_MRD, S_MWR, S_FSET, S_FRD, S_FCHK, S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  in_t              req_r, req_nxt;
  logic [SW-1:0]    row_r, row_nxt;      // current row, also clear sweep
  logic [SW-1:0]    rend_r, rend_nxt;    // mark stop row
  logic [SW-1:0]    xmax_r, xmax_nxt;
  logic [SW-1:0]    ymax_r, ymax_nxt;
  logic [SW-1:0]    xi_r, xi_nxt;        // column offset of candidate
  logic [SW-1:0]    yi_r, yi_nxt;        // row offset of candidate
  logic             found_r, found_nxt;
  logic             out_valid_r;
  out_t             out_r;

  logic             ram_we;
  logic [GRID_COLS-1:0] ram_wdata, ram_rdata, mask;
  logic [SW-1:0]    cand_x, cand_y, lo, hi;
  logic [SW-1:0]    bx, by, w, h, xe, ye, xlast, ylast;
  logic             okx, oky, conflict, last_inner, last_outer;

  rsa_ram #(.WIDTH(GRID_COLS), .DEPTH(GRID_ROWS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (row_r[AW-1:0]),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // window bounds, clipped to the grid
  always_comb begin
    bx = SW'(req_r.bound_x);
    by = SW'(req_r.bound_y);
    w  = SW'(req_r.rect_width);
    h  = SW'(req_r.rect_height);
    xe = bx + SW'(req_r.bound_w);
    if (xe > SW'(GRID_COLS)) xe = SW'(GRID_COLS);
    ye = by + SW'(req_r.bound_h);
    if (ye > SW'(GRID_ROWS)) ye = SW'(GRID_ROWS);
    okx = (w != '0) && (req_r.rect_width <= req_r.bound_w) && (xe >= bx + w);
    oky = (h != '0) && (req_r.rect_height <= req_r.bound_h) && (ye >= by + h);
  end

  // candidate corner in scan order
  always_comb begin
    cand_x = req_r.left_to_right ? bx + xi_r : xmax_r - xi_r;
    cand_y = req_r.top_to_bottom ? by + yi_r : ymax_r - yi_r;
    xlast  = xmax_r - bx;
    ylast  = ymax_r - by;
  end

  // column span mask: find uses the candidate, marks the request
  always_comb begin
    if (state_r == S_FCHK) begin
      lo = cand_x;
      hi = cand_x + w;
    end else begin
      lo = SW'(req_r.x_pos);
      hi = SW'(req_r.x_pos) + w;
    end
    for (int i = 0; i < GRID_COLS; i++) begin
      mask[i] = (SW'(i) >= lo) && (SW'(i) < hi);
    end
  end

  assign conflict   = |(ram_rdata & mask);
  assign last_inner = req_r.row_first ? (xi_r == xlast) : (yi_r == ylast);
  assign last_outer = req_r.row_first ? (yi_r == ylast) : (xi_r == xlast);

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    if (state_r == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state_r == S_MWR) begin
      ram_we    = 1'b1;
      ram_wdata = (req_r.action == ACT_MARK_USED) ? (ram_rdata | mask)
                                                  : (ram_rdata & ~mask);
    end
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    row_nxt   = row_r;
    rend_nxt  = rend_r;
    xmax_nxt  = xmax_r;
    ymax_nxt  = ymax_r;
    xi_nxt    = xi_r;
    yi_nxt    = yi_r;
    found_nxt = found_r;
    case (state_r)
      S_CLEAR: begin
        row_nxt = row_r + 1'b1;
        if (row_r == SW'(GRID_ROWS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          req_nxt = in_item;
          case (in_item.action)
            ACT_FIND:      state_nxt = S_FSET;
            ACT_MARK_USED: state_nxt = S_MSET;
            ACT_MARK_FREE: state_nxt = S_MSET;
            default:       state_nxt = S_IDLE;
          endcase
        end
      end
      S_MSET: begin
        row_nxt  = SW'(req_r.y_pos);
        rend_nxt = SW'(req_r.y_pos) + h;
        if (rend_nxt > SW'(GRID_ROWS)) rend_nxt = SW'(GRID_ROWS);
        state_nxt = (rend_nxt > SW'(req_r.y_pos)) ? S_MRD : S_IDLE;
      end
      S_MRD: state_nxt = S_MWR;
      S_MWR: begin
        row_nxt   = row_r + 1'b1;
        state_nxt = (row_r + 1'b1 >= rend_r) ? S_IDLE : S_MRD;
      end
      S_FSET: begin
        xmax_nxt = xe - w;
        if (xmax_nxt > SW'(COORD_MAX)) xmax_nxt = SW'(COORD_MAX);
        ymax_nxt = ye - h;
        if (ymax_nxt > SW'(COORD_MAX)) ymax_nxt = SW'(COORD_MAX);
        xi_nxt    = '0;
        yi_nxt    = '0;
        found_nxt = 1'b0;
        if (okx && oky && xmax_nxt >= bx && ymax_nxt >= by) begin
          row_nxt   = req_r.top_to_bottom ? by : ymax_nxt;
          state_nxt = S_FRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FRD: state_nxt = S_FCHK;
      S_FCHK: begin
        if (conflict) begin
          // move to next candidate in scan order
          if (last_inner && last_outer) begin
            state_nxt = S_DONE;
          end else begin
            if (req_r.row_first) begin
              if (last_inner) begin
                xi_nxt = '0;
                yi_nxt = yi_r + 1'b1;
              end else begin
                xi_nxt = xi_r + 1'b1;
              end
            end else begin
              if (last_inner) begin
                yi_nxt = '0;
                xi_nxt = xi_r + 1'b1;
              end else begin
                yi_nxt = yi_r + 1'b1;
              end
            end
            row_nxt   = req_r.top_to_bottom ? by + yi_nxt : ymax_r - yi_nxt;
            state_nxt = S_FRD;
          end
        end else if (row_r == cand_y + h - 1'b1) begin
          found_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          row_nxt   = row_r + 1'b1;
          state_nxt = S_FRD;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      found_r     <= found_nxt;
      out_valid_r <= (state_r == S_DONE);
    end
    req_r  <= req_nxt;
    rend_r <= rend_nxt;
    xmax_r <= xmax_nxt;
    ymax_r <= ymax_nxt;
    xi_r   <= xi_nxt;
    yi_r   <= yi_nxt;
    if (state_r == S_DONE) begin
      out_r.found    <= found_r;
      out_r.result_x <= found_r ? cand_x[6:0] : 7'd0;
      out_r.result_y <= found_r ? cand_y[6:0] : 7'd0;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.found) |-> (out_item.result_x == 7'd0 &&
    out_item.result_y == 7'd0)) else $error("not-found result with nonzero corner");
  a_find_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.action == ACT_FIND) |=> busy)
    else $error("find accepted without going busy");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(out_valid)) else $error("back-to-back result strobes");

endmodule

FILE: src/rsa_ram.sv
module rsa_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 128
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                             wdata,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rsa_pkg::*;

  localparam int ROWS = 128;
  localparam int COLS = 128;
  localparam int N_RANDOM = 1930;
  localparam int CYCLE_LIMIT = 20000000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  in_t   in_item = '0;
  logic  out_valid;
  out_t  out_item;

  rect_space_allocator #(.GRID_ROWS(ROWS), .GRID_COLS(COLS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always #10 clk = ~clk;

  // shadow copy of the occupancy bitmap, set bit = used cell
  logic [COLS-1:0] occ_shadow [ROWS];
  out_t  pending_finds[$];
  int    mismatches = 0;
  int    cycles = 0;
  int    idle_pct = 0;

  // typed expectation for the directed beat being driven
  bit    cur_typed = 0;
  out_t  cur_want;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic report_mismatch(string what, out_t got, out_t want);
    $display("mismatch %s: got found=%0d x=%0d y=%0d, want found=%0d x=%0d y=%0d",
             what, got.found, got.result_x, got.result_y,
             want.found, want.result_x, want.result_y);
    mismatches++;
  endtask

  // mark-used / mark-free with clipping at the grid edges
  function automatic void apply_mark(in_t it, bit set_used);
    int x, y, w, h, stop;
    x = it.x_pos; y = it.y_pos; w = it.rect_width; h = it.rect_height;
    if (x >= COLS || w == 0) return;
    stop = (x + w > COLS) ? COLS : x + w;
    for (int r = y; r < y + h && r < ROWS; r++)
      for (int c = x; c < stop; c++)
        occ_shadow[r][c] = set_used;
  endfunction

  // legal corner range along one axis, clipped to grid and 7-bit coordinates
  function automatic bit corner_range(int b, int bsize, int size, int limit,
                                      output int maxs);
    int e;
    e = (b + bsize > limit) ? limit : b + bsize;
    maxs = 0;
    if (size == 0 || size > bsize || e < b + size) return 0;
    maxs = e - size;
    if (maxs > COORD_MAX) maxs = COORD_MAX;
    return maxs >= b;
  endfunction

  function automatic bit area_free(int x, int y, int w, int h);
    logic [2*COLS-1:0] span, row;
    span = ((2*COLS)'(1) << w) - 1;
    span = span << x;
    for (int r = y; r < y + h; r++) begin
      if (r >= ROWS) return 0;
      row = {{COLS{1'b1}}, occ_shadow[r]};  // cells past the right edge are unusable
      if ((row & span) != 0) return 0;
    end
    return 1;
  endfunction

  // first fit in the requested scan order
  function automatic out_t first_fit(in_t it);
    out_t res;
    int xmax, ymax, nx, ny, xi, yi, x, y;
    res = '0;
    if (!corner_range(it.bound_x, it.bound_w, it.rect_width, COLS, xmax)) return res;
    if (!corner_range(it.bound_y, it.bound_h, it.rect_height, ROWS, ymax)) return res;
    nx = xmax - it.bound_x + 1;
    ny = ymax - it.bound_y + 1;
    for (int i = 0; i < (it.row_first ? ny : nx); i++)
      for (int j = 0; j < (it.row_first ? nx : ny); j++) begin
        yi = it.row_first ? i : j;
        xi = it.row_first ? j : i;
        x = it.left_to_right ? it.bound_x + xi : xmax - xi;
        y = it.top_to_bottom ? it.bound_y + yi : ymax - yi;
        if (area_free(x, y, it.rect_width, it.rect_height)) begin
          res.found = 1'b1;
          res.result_x = x[6:0];
          res.result_y = y[6:0];
          return res;
        end
      end
    return res;
  endfunction

  function automatic in_t mk(logic [1:0] act, int x, int y, int w, int h,
                             int bx, int by, int bw, int bh,
                             bit t2b, bit l2r, bit rf);
    in_t it;
    it.action = act; it.x_pos = 7'(x); it.y_pos = 7'(y);
    it.rect_width = 8'(w); it.rect_height = 8'(h);
    it.bound_x = 7'(bx); it.bound_y = 7'(by); it.bound_w = 8'(bw); it.bound_h = 8'(bh);
    it.top_to_bottom = t2b; it.left_to_right = l2r; it.row_first = rf;
    return it;
  endfunction

  function automatic out_t res(bit f, int x, int y);
    out_t o;
    o.found = f; o.result_x = 7'(x); o.result_y = 7'(y);
    return o;
  endfunction

  function automatic void add_row(in_t it, bit typed = 0, out_t want = '0);
    dir_row_t d;
    d.item = it; d.typed = typed; d.want = want;
    dir_rows.push_back(d);
  endfunction

  // random beat: every field noise first, then shaped by action
  function automatic in_t random_beat();
    in_t it;
    int k, bw, bh;
    it = in_t'($bits(in_t)'({$urandom, $urandom, $urandom}));
    k = $urandom_range(99);
    if (k < 3) begin
      it.action = ACT_UNUSED;
    end else if (k < 25) begin
      it.action = ACT_MARK_USED;
      it.rect_width = 8'($urandom_range(1, 8));
      it.rect_height = 8'($urandom_range(1, 8));
      if ($urandom_range(15) == 0) it.rect_width = 8'($urandom_range(0, 255));
      if ($urandom_range(15) == 0) it.rect_height = 8'($urandom_range(0, 255));
    end else if (k < 40) begin
      it.action = ACT_MARK_FREE;
      it.rect_width = 8'($urandom_range(1, 24));
      it.rect_height = 8'($urandom_range(1, 24));
      if ($urandom_range(15) == 0) it.rect_width = 8'($urandom_range(0, 255));
      if ($urandom_range(15) == 0) it.rect_height = 8'($urandom_range(0, 255));
    end else begin
      it.action = ACT_FIND;
      k = $urandom_range(99);
      if (k < 85) begin
        // small window keeps the scan short
        it.bound_w = 8'($urandom_range(1, 12));
        it.bound_h = 8'($urandom_range(1, 12));
        it.rect_width = 8'($urandom_range(1, 4));
        it.rect_height = 8'($urandom_range(1, 4));
      end else if (k < 92) begin
        // near-full window with a near-window-sized rectangle, few corners
        bw = $urandom_range(100, 128);
        bh = $urandom_range(100, 128);
        it.bound_w = 8'(bw); it.bound_h = 8'(bh);
        it.bound_x = 7'($urandom_range(0, 8));
        it.bound_y = 7'($urandom_range(0, 8));
        it.rect_width = 8'(bw - int'($urandom_range(0, 3)));
        it.rect_height = 8'(bh - int'($urandom_range(0, 3)));
      end else begin
        // degenerate: zero size, oversize, or window hanging off the grid
        it.bound_w = 8'($urandom_range(1, 255));
        it.bound_h = 8'($urandom_range(1, 255));
        it.rect_width = $urandom_range(0, 1) ? 8'd0 : 8'd255;
        it.rect_height = 8'($urandom_range(0, 255));
      end
    end
    return it;
  endfunction

  // one beat, start held until the block takes it
  task automatic drive_beat(in_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // predictor and checker, both at the rising edge
  always @(posedge clk) begin
    out_t predicted;
    if (rst_n) begin
      if (start && !busy) begin
        case (in_item.action)
          ACT_FIND: begin
            predicted = first_fit(in_item);
            if (cur_typed && predicted != cur_want)
              report_mismatch("directed find", predicted, cur_want);
            pending_finds.push_back(predicted);
          end
          ACT_MARK_USED: apply_mark(in_item, 1'b1);
          ACT_MARK_FREE: apply_mark(in_item, 1'b0);
          default: ;  // unused action does nothing
        endcase
      end
      if (out_valid) begin
        if (pending_finds.size() == 0)
          report_mismatch("unexpected result", out_item, '0);
        else begin
          predicted = pending_finds.pop_front();
          if (out_item != predicted) report_mismatch("find result", out_item, predicted);
        end
      end
    end
  end

  // timeout guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int r = 0; r < ROWS; r++) occ_shadow[r] = '0;

    // fresh map: whole-grid finds succeed at the origin
    add_row(mk(ACT_FIND, 0, 0, 1, 1, 0, 0, 128, 128, 1, 1, 1), 1, res(1, 0, 0));
    add_row(mk(ACT_FIND, 0, 0, 128, 128, 0, 0, 128, 128, 1, 1, 0), 1, res(1, 0, 0));
    // zero width, and rectangle wider than the window
    add_row(mk(ACT_FIND, 0, 0, 0, 4, 0, 0, 128, 128, 1, 1, 1), 1, res(0, 0, 0));
    add_row(mk(ACT_FIND, 0, 0, 5, 1, 10, 10, 4, 4, 1, 1, 1), 1, res(0, 0, 0));
    // window hanging off the right edge
    add_row(mk(ACT_FIND, 0, 0, 2, 1, 127, 0, 128, 1, 1, 1, 1), 1, res(0, 0, 0));
    // zero-size marks and the unused action change nothing
    add_row(mk(ACT_MARK_USED, 0, 0, 0, 5, 0, 0, 1, 1, 0, 0, 0));
    add_row(mk(ACT_MARK_USED, 3, 3, 5, 0, 0, 0, 1, 1, 0, 0, 0));
    add_row(mk(ACT_UNUSED, 0, 0, 128, 128, 0, 0, 1, 1, 0, 0, 0));
    // fill the whole grid
    add_row(mk(ACT_MARK_USED, 0, 0, 128, 128, 0, 0, 1, 1, 0, 0, 0));
    add_row(mk(ACT_FIND, 0, 0, 1, 1, 0, 0, 128, 128, 1, 1, 1), 1, res(0, 0, 0));
    // clipped frees at the far corner and right edge
    add_row(mk(ACT_MARK_FREE, 127, 127, 128, 128, 0, 0, 1, 1, 0, 0, 0));
    add_row(mk(ACT_FIND, 0, 0, 1, 1, 120, 120, 8, 8, 0, 0, 1), 1, res(1, 127, 127));
    add_row(mk(ACT_MARK_FREE, 120, 0, 255, 255, 0, 0, 1, 1, 0, 0, 0));
    add_row(mk(ACT_FIND, 0, 0, 8, 128, 0, 0, 128, 128, 1, 1, 1), 1, res(1, 120, 0));
    // clear all, block the middle, then every scan order
    add_row(mk(ACT_MARK_FREE, 0, 0, 128, 128, 0, 0, 1, 1, 0, 0, 0));
    add_row(mk(ACT_MARK_USED, 40, 40, 20, 20, 0, 0, 1, 1, 0, 0, 0));
    for (int o = 0; o < 8; o++)
      add_row(mk(ACT_FIND, 0, 0, 30, 30, 20, 20, 70, 70, o[2], o[1], o[0]));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      cur_typed = dir_rows[i].typed;
      cur_want = dir_rows[i].want;
      drive_beat(dir_rows[i].item);
    end
    cur_typed = 0;

    // idling phases: none, 61 in a hundred, none again, 31 in a hundred
    for (int i = 0; i < N_RANDOM; i++) begin
      case (i * 4 / N_RANDOM)
        0: idle_pct = 0;
        1: idle_pct = 61;
        2: idle_pct = 0;
        default: idle_pct = 31;
      endcase
      drive_beat(random_beat());
    end
    start <= 1'b0;

    // drain: nothing pending, block idle, then a quiet stretch
    while (pending_finds.size() != 0 || busy) @(posedge clk);
    repeat (300) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/rsa_pkg.sv
src/rsa_ram.sv
src/rect_space_allocator.sv
tb/tb_top.sv
